/* design/fye_pkg.sv */
// ----------------------------------------------------------------------------
// fye_pkg: shared types, codes and microcode for the permutation engine
// Holds the field widths, the operation and status codes, the microcode
// word layout and the read-only control store with its dispatch table.
// ----------------------------------------------------------------------------
package fye_pkg;

  localparam int OP_W      = 2;
  localparam int POS_W     = 10;
  localparam int ENTRY_W   = 10;
  localparam int STATUS_W  = 2;
  localparam int DATA_W    = 16;
  localparam int SIZE_W    = 11;
  localparam int SEED_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIVCNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd2;

  localparam logic [SEED_W-1:0]   LCG_MUL  = 32'd1664525;
  localparam logic [SEED_W-1:0]   LCG_ADD  = 32'd1013904223;
  localparam logic [SEED_W-1:0]   LCG_ONE  = 32'd1;
  localparam logic [DIVCNT_W-1:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    U_IDLE, U_RDOUT, U_INIT, U_INIT_CHK, U_INIT_WR, U_SHUF, U_S_CHK,
    U_S_LCG, U_S_DIVINIT, U_S_DIV, U_S_RD, U_S_WA, U_S_WB, U_DONE
  } upc_t;

  typedef enum logic [3:0] {
    A_NONE, A_ACCEPT, A_EMIT_READ, A_INIT_LOAD, A_FILL, A_LOAD_I, A_LCG_STEP,
    A_DIV_INIT, A_DIV_STEP, A_SWAP_READ, A_WRITE_HI, A_WRITE_LO, A_EMIT_DONE
  } action_t;

  typedef enum logic [2:0] {
    C_NEVER, C_DISPATCH, C_OUT_BUSY, C_K_AT_CNT, C_SHUF_OFF, C_I_LE_ONE,
    C_DIV_MORE
  } cond_t;

  // One control word: the datapath action, a jump condition with its
  // target, and the fall-through address taken when the condition fails.
  typedef struct packed {
    action_t act;
    cond_t   cond;
    upc_t    jump;
    upc_t    next;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic k_at_cnt;
    logic shuffle_off;
    logic i_le_one;
    logic div_more;
  } ucond_t;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    unique case (addr)
      U_IDLE:      w = '{A_ACCEPT,    C_DISPATCH, U_IDLE,   U_IDLE};
      U_RDOUT:     w = '{A_EMIT_READ, C_OUT_BUSY, U_RDOUT,  U_IDLE};
      U_INIT:      w = '{A_INIT_LOAD, C_NEVER,    U_IDLE,   U_INIT_CHK};
      U_INIT_CHK:  w = '{A_NONE,      C_K_AT_CNT, U_SHUF,   U_INIT_WR};
      U_INIT_WR:   w = '{A_FILL,      C_NEVER,    U_IDLE,   U_INIT_CHK};
      U_SHUF:      w = '{A_LOAD_I,    C_SHUF_OFF, U_DONE,   U_S_CHK};
      U_S_CHK:     w = '{A_NONE,      C_I_LE_ONE, U_DONE,   U_S_LCG};
      U_S_LCG:     w = '{A_LCG_STEP,  C_NEVER,    U_IDLE,   U_S_DIVINIT};
      U_S_DIVINIT: w = '{A_DIV_INIT,  C_NEVER,    U_IDLE,   U_S_DIV};
      U_S_DIV:     w = '{A_DIV_STEP,  C_DIV_MORE, U_S_DIV,  U_S_RD};
      U_S_RD:      w = '{A_SWAP_READ, C_NEVER,    U_IDLE,   U_S_WA};
      U_S_WA:      w = '{A_WRITE_HI,  C_NEVER,    U_IDLE,   U_S_WB};
      U_S_WB:      w = '{A_WRITE_LO,  C_NEVER,    U_IDLE,   U_S_CHK};
      U_DONE:      w = '{A_EMIT_DONE, C_OUT_BUSY, U_DONE,   U_IDLE};
      default:     w = '{A_NONE,      C_NEVER,    U_IDLE,   U_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(input logic [OP_W-1:0] op);
    upc_t t;
    unique case (op)
      OP_INIT:    t = U_INIT;
      OP_SHUFFLE: t = U_SHUF;
      OP_READ:    t = U_RDOUT;
      OP_NOP:     t = U_DONE;
      default:    t = U_DONE;
    endcase
    return t;
  endfunction

endpackage

/* design/fye_seq.sv */
// ----------------------------------------------------------------------------
// fye_seq: microcode sequencer
// Step counter over the read-only control store, with conditional jumps
// and an opcode dispatch at the idle step.
// ----------------------------------------------------------------------------
module fye_seq
  import fye_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  ucond_t          flags,
  input  logic [OP_W-1:0] op,
  output ucode_t          ctl
);

  upc_t upc;
  upc_t upc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    ctl = ucode_rom(upc);
  end

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:    upc_next = ctl.next;
      C_DISPATCH: upc_next = flags.in_valid ? dispatch(op) : ctl.jump;
      C_OUT_BUSY: upc_next = flags.out_busy ? ctl.jump : ctl.next;
      C_K_AT_CNT: upc_next = flags.k_at_cnt ? ctl.jump : ctl.next;
      C_SHUF_OFF: upc_next = flags.shuffle_off ? ctl.jump : ctl.next;
      C_I_LE_ONE: upc_next = flags.i_le_one ? ctl.jump : ctl.next;
      C_DIV_MORE: upc_next = flags.div_more ? ctl.jump : ctl.next;
      default:    upc_next = U_IDLE;
    endcase
  end

endmodule

/* design/fisher_yates_permutation_engine.sv */
// ----------------------------------------------------------------------------
// fisher_yates_permutation_engine: shuffled index table with an LCG
// Read: the table is read at accept and the result registered once the output
// is free; one item at a time. Init: fills the table, then runs the shuffle
// when enabled. Shuffle: (N-1) swaps, each via the 32-step remainder unit.
// Reset clears the sequencer, output valid, count, LCG state and config
// registers; the table has no clearing pass and is defined only after an init.
// ----------------------------------------------------------------------------
module fisher_yates_permutation_engine
  import fye_pkg::*;
#(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,   // [9:0] position, rest zero
  input  logic [OP_W-1:0]      s_tuser,   // [1:0] op
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [DATA_W-1:0]    m_tdata,   // [9:0] entry, rest zero
  output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > SIZE_W) ? CW : SIZE_W;

  logic [ENTRY_W-1:0] mem [MAX_ITEMS];

  ucode_t ctl;
  ucond_t flags;

  logic [SIZE_W-1:0]   size_cfg;
  logic                shuf_en;
  logic [SEED_W-1:0]   seed;
  logic [CW-1:0]       cnt;
  logic [SEED_W-1:0]   lcg;
  logic [CW-1:0]       k;
  logic [CW-1:0]       i_cnt;
  logic [CW-1:0]       rem;
  logic [SEED_W-1:0]   dvd;
  logic [DIVCNT_W-1:0] bitcnt;
  logic [POS_W-1:0]    pos_reg;
  logic [ENTRY_W-1:0]  rd_a;
  logic [ENTRY_W-1:0]  rd_b;
  logic [ENTRY_W-1:0]  out_entry;
  logic [STATUS_W-1:0] out_status;

  logic                out_busy;
  logic                emit;
  logic [CMPW-1:0]     size_ext;
  logic [CMPW-1:0]     sat_ext;
  logic [CMPW-1:0]     k_ext;
  logic [CMPW-1:0]     pos_in_ext;
  logic [CMPW-1:0]     pos_reg_ext;
  logic                in_range;
  logic [CW-1:0]       i_dec;
  logic [CW:0]         trial;
  logic [CW:0]         diff;
  logic                ge;
  logic [CW-1:0]       rem_next;
  logic [AW-1:0]       addr_a;
  logic                rd_en;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [ENTRY_W-1:0]  wdata;

  fye_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (s_tuser),
    .ctl   (ctl)
  );

  assign s_tready  = (ctl.act == A_ACCEPT);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(DATA_W - ENTRY_W){1'b0}}, out_entry};
  assign m_tuser   = out_status;

  assign out_busy = m_tvalid && !m_tready;
  assign emit     = ((ctl.act == A_EMIT_READ) || (ctl.act == A_EMIT_DONE)) && !out_busy;

  always_comb begin
    size_ext    = CMPW'(size_cfg);
    sat_ext     = (size_ext > CMPW'(MAX_ITEMS)) ? CMPW'(MAX_ITEMS) : size_ext;
    k_ext       = CMPW'(k);
    pos_in_ext  = CMPW'(s_tdata[POS_W-1:0]);
    pos_reg_ext = CMPW'(pos_reg);
    in_range    = pos_reg_ext < CMPW'(cnt);
    i_dec       = i_cnt - CW'(1);
    // Restoring remainder: one dividend bit enters per step.
    trial       = {rem, dvd[SEED_W-1]};
    ge          = trial >= {1'b0, i_cnt};
    diff        = trial - {1'b0, i_cnt};
    rem_next    = ge ? diff[CW-1:0] : trial[CW-1:0];
  end

  always_comb begin
    flags.in_valid    = s_tvalid;
    flags.out_busy    = out_busy;
    flags.k_at_cnt    = (k == cnt);
    flags.shuffle_off = !shuf_en;
    flags.i_le_one    = (i_cnt <= CW'(1));
    flags.div_more    = (bitcnt != DIV_LAST);
  end

  // Port A reads the requested position at accept time, or the top entry
  // of the swap; port B always reads the entry picked by the remainder.
  always_comb begin
    rd_en  = (ctl.act == A_ACCEPT) || (ctl.act == A_SWAP_READ);
    addr_a = (ctl.act == A_ACCEPT) ? pos_in_ext[AW-1:0] : i_dec[AW-1:0];
    we     = 1'b0;
    waddr  = k[AW-1:0];
    wdata  = k_ext[ENTRY_W-1:0];
    unique case (ctl.act)
      A_FILL: begin
        we = !flags.k_at_cnt;
      end
      A_WRITE_HI: begin
        we    = 1'b1;
        waddr = i_dec[AW-1:0];
        wdata = rd_b;
      end
      A_WRITE_LO: begin
        we    = 1'b1;
        waddr = rem[AW-1:0];
        wdata = rd_a;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[rem[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= '0;
      shuf_en  <= 1'b0;
      seed     <= LCG_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE:    size_cfg <= cfg_data[SIZE_W-1:0];
        CFG_SHUFFLE: shuf_en  <= cfg_data[0];
        CFG_SEED:    seed     <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      lcg <= LCG_ONE;
    end else if (ctl.act == A_INIT_LOAD) begin
      cnt <= sat_ext[CW-1:0];
      lcg <= (seed != '0) ? seed : LCG_ONE;
    end else if (ctl.act == A_LCG_STEP) begin
      lcg <= lcg * LCG_MUL + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.act)
      A_ACCEPT: begin
        pos_reg <= s_tdata[POS_W-1:0];
      end
      A_INIT_LOAD: begin
        k <= '0;
      end
      A_FILL: begin
        k <= k + CW'(1);
      end
      A_LOAD_I: begin
        i_cnt <= cnt;
      end
      A_DIV_INIT: begin
        rem    <= '0;
        dvd    <= lcg;
        bitcnt <= '0;
      end
      A_DIV_STEP: begin
        rem    <= rem_next;
        dvd    <= {dvd[SEED_W-2:0], 1'b0};
        bitcnt <= bitcnt + DIVCNT_W'(1);
      end
      A_WRITE_LO: begin
        i_cnt <= i_dec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctl.act == A_EMIT_READ) begin
        out_entry  <= in_range ? rd_a : '0;
        out_status <= in_range ? ST_OK : ST_RANGE;
      end else begin
        out_entry  <= '0;
        out_status <= ST_DONE;
      end
    end
  end

`ifndef SYNTHESIS
  // After a transaction is taken the sequencer leaves the idle step.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on two consecutive cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_ITEMS))
    else $error("entry count above table depth");

  // The swap partner must lie at or below the current top entry.
  a_swap_index: assert property (@(posedge clk) disable iff (rst)
    ctl.act == A_SWAP_READ |-> (rem < i_cnt) && (i_cnt > CW'(1)))
    else $error("swap index out of range");
`endif

endmodule
